>>> rtl/msc_pkg.sv
// Signature table and type codes for the magic signature classifier.
// No dependencies; used by magic_signature_classifier.

package msc_pkg;

  localparam int RowCount = 16;
  localparam int RiffRow  = 15;
  localparam int MagicMax = 8;

  localparam logic [3:0] PosMax = 4'd15;

  localparam logic [3:0] CodeNone     = 4'd0;
  localparam logic [3:0] CodeZip      = 4'd1;
  localparam logic [3:0] CodePdf      = 4'd2;
  localparam logic [3:0] CodePng      = 4'd3;
  localparam logic [3:0] CodeJpeg     = 4'd4;
  localparam logic [3:0] CodeGif      = 4'd5;
  localparam logic [3:0] CodeTiff     = 4'd6;
  localparam logic [3:0] CodeWebp     = 4'd7;
  localparam logic [3:0] CodeBmp      = 4'd8;
  localparam logic [3:0] CodeGzip     = 4'd9;
  localparam logic [3:0] CodeWarc     = 4'd10;
  localparam logic [3:0] CodeRtf      = 4'd11;
  localparam logic [3:0] CodePs       = 4'd12;
  localparam logic [3:0] CodeCompound = 4'd13;
  localparam logic [3:0] CodeMaxValid = CodeCompound;

  typedef logic [RowCount-1:0] row_mask_t;

  // Row order: zip, pdf, png, jpeg, gif87a, gif89a, tiff II, tiff MM,
  // webp tag, bmp, gzip, warc, rtf, ps, compound, riff.
  localparam logic [7:0] Magic [RowCount][MagicMax] = '{
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
    '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h45, 8'h42, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h41, 8'h52, 8'h43, 8'h2F, 8'h00, 8'h00, 8'h00},
    '{8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h21, 8'h50, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] Offset [RowCount] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  localparam logic [3:0] Len [RowCount] = '{
    4'd4, 4'd5, 4'd8, 4'd3, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd4, 4'd2, 4'd2, 4'd5, 4'd5, 4'd4, 4'd8, 4'd4
  };

  localparam logic [3:0] MinCount [RowCount] = '{
    4'd4, 4'd5, 4'd8, 4'd3, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd12, 4'd14, 4'd2, 4'd5, 4'd5, 4'd4, 4'd8, 4'd4
  };

  localparam logic [3:0] Code [RowCount] = '{
    CodeZip, CodePdf, CodePng, CodeJpeg, CodeGif, CodeGif, CodeTiff, CodeTiff,
    CodeWebp, CodeBmp, CodeGzip, CodeWarc, CodeRtf, CodePs, CodeCompound, CodeNone
  };

endpackage

>>> rtl/magic_signature_classifier.sv
// Magic signature classifier top level: input register, per-row compare,
// result register. Depends on msc_pkg.

// Takes a file body one byte per item on the slave stream, tlast on the final
// byte, and returns one type code per body on the master stream: the last byte
// passes the input register, then its code is held in the result register. One
// byte is accepted every cycle; the only stall is a last byte held in the input
// register while the previous result is still waiting in the result register.
// All sixteen rows are compared against the registered byte in parallel each cycle.
module magic_signature_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [3:0] type_code, [7:4] zero
);

  logic                 in_valid_q;
  logic [7:0]           data_q;
  logic                 last_q;
  logic [3:0]           pos_q, pos_d;
  msc_pkg::row_mask_t   alive_q, alive_d, alive_upd;
  logic                 out_valid_q;
  logic [3:0]           code_q, code_d;
  logic [3:0]           count;
  logic                 out_free;
  logic                 adv;
  logic                 riff_ok;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && (!last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_comb begin
    logic [3:0] diff;
    logic [4:0] win_end;
    logic       ok;
    alive_upd = alive_q;
    for (int r = 0; r < msc_pkg::RowCount; r++) begin
      diff    = pos_q - msc_pkg::Offset[r];
      win_end = {1'b0, msc_pkg::Offset[r]} + {1'b0, msc_pkg::Len[r]};
      if ((pos_q >= msc_pkg::Offset[r]) && ({1'b0, pos_q} < win_end) &&
          (msc_pkg::Magic[r][diff[2:0]] != data_q)) begin
        alive_upd[r] = 1'b0;
      end
    end
    count = (pos_q < msc_pkg::PosMax) ? pos_q + 4'd1 : msc_pkg::PosMax;

    riff_ok = alive_upd[msc_pkg::RiffRow] &&
              (count >= msc_pkg::MinCount[msc_pkg::RiffRow]);
    code_d  = msc_pkg::CodeNone;
    for (int r = msc_pkg::RiffRow - 1; r >= 0; r--) begin
      ok = alive_upd[r] && (count >= msc_pkg::MinCount[r]);
      if (msc_pkg::Code[r] == msc_pkg::CodeWebp) begin
        ok = ok && riff_ok;
      end
      if (ok) begin
        code_d = msc_pkg::Code[r];
      end
    end

    if (last_q) begin
      pos_d   = '0;
      alive_d = '1;
    end else begin
      pos_d   = count;
      alive_d = alive_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      data_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alive_q <= '1;
    end else if (adv) begin
      pos_q   <= pos_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      code_q <= code_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, code_q};

  // end of body restores tracking state
  a_end_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (pos_q == '0) && (alive_q == '1))
    else $error("state not restored after last byte");

  // position saturates
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !last_q && pos_q == msc_pkg::PosMax) |=> (pos_q == msc_pkg::PosMax))
    else $error("byte position wrapped");

  // a pending last byte cannot overrun a result that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && last_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("result register overrun");

  // code range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (code_q <= msc_pkg::CodeMaxValid))
    else $error("type code out of range");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for magic_signature_classifier: drives file bodies on
// the input stream and checks each type code against an in-bench predictor.
// Depends on msc_pkg (type codes) and the classifier RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {RxAlways, RxRandom, RxPeriodic} rx_mode_e;

  localparam int SigRows    = 16;
  localparam int HoldCycles = 300;
  localparam int LimitNs    = 2_000_000;
  localparam int RandBytes  = 360;
  localparam logic [3:0] CountCap = 4'd15;

  localparam int RowZip      = 0;
  localparam int RowPdf      = 1;
  localparam int RowPng      = 2;
  localparam int RowJpeg     = 3;
  localparam int RowGif87    = 4;
  localparam int RowGif89    = 5;
  localparam int RowTiffLe   = 6;
  localparam int RowTiffBe   = 7;
  localparam int RowWebp     = 8;
  localparam int RowBmp      = 9;
  localparam int RowGzip     = 10;
  localparam int RowWarc     = 11;
  localparam int RowRtf      = 12;
  localparam int RowPs       = 13;
  localparam int RowCompound = 14;
  localparam int RowRiff     = 15;

  localparam logic [7:0] SigBytes [SigRows][8] = '{
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
    '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h45, 8'h42, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h41, 8'h52, 8'h43, 8'h2F, 8'h00, 8'h00, 8'h00},
    '{8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h21, 8'h50, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int SigOffset [SigRows] = '{0, 0, 0, 0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0, 0};
  localparam int SigLength [SigRows] = '{4, 5, 8, 3, 6, 6, 4, 4, 4, 2, 2, 5, 5, 4, 8, 4};
  localparam int SigMinBytes [SigRows] =
    '{4, 5, 8, 3, 6, 6, 4, 4, 12, 14, 2, 5, 5, 4, 8, 4};
  localparam logic [3:0] SigType [SigRows] = '{
    msc_pkg::CodeZip, msc_pkg::CodePdf, msc_pkg::CodePng, msc_pkg::CodeJpeg,
    msc_pkg::CodeGif, msc_pkg::CodeGif, msc_pkg::CodeTiff, msc_pkg::CodeTiff,
    msc_pkg::CodeWebp, msc_pkg::CodeBmp, msc_pkg::CodeGzip, msc_pkg::CodeWarc,
    msc_pkg::CodeRtf, msc_pkg::CodePs, msc_pkg::CodeCompound, msc_pkg::CodeNone
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] data_byte
  logic       s_axis_tlast_i;   // last_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [3:0] type_code, [7:4] zero

  logic [3:0]  sig_pos;
  logic [15:0] sig_alive;
  logic [3:0]  expected_types[$];
  int          err_count;
  int          bytes_sent;
  int          burst_left;
  bit          gaps_on;
  logic        hold_on;
  event        hold_ev;

  magic_signature_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t tb_top: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  // Advance the predictor by one accepted byte; a final byte yields a type code.
  task automatic classify_byte(input logic [7:0] b, input logic is_last);
    int         p;
    logic [3:0] cnt;
    logic [3:0] found_type;
    logic       riff_ok;
    logic       hit;
    p = int'(sig_pos);
    for (int r = 0; r < SigRows; r++) begin
      if (p >= SigOffset[r] && p < SigOffset[r] + SigLength[r] &&
          SigBytes[r][p - SigOffset[r]] != b)
        sig_alive[r] = 1'b0;
    end
    cnt = (sig_pos == CountCap) ? CountCap : sig_pos + 4'd1;
    sig_pos = cnt;
    if (is_last) begin
      riff_ok = sig_alive[RowRiff] && int'(cnt) >= SigMinBytes[RowRiff];
      found_type = msc_pkg::CodeNone;
      hit = 1'b0;
      for (int r = 0; r < RowRiff; r++) begin
        if (!hit && sig_alive[r] && int'(cnt) >= SigMinBytes[r] &&
            (r != RowWebp || riff_ok)) begin
          found_type = SigType[r];
          hit = 1'b1;
        end
      end
      expected_types = {expected_types, found_type};
      sig_pos = 4'd0;
      sig_alive = '1;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    classify_byte(b, is_last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_body(input byte_q_t q);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_types.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random bytes with one row's magic laid over them; webp also gets its RIFF tag.
  function automatic byte_q_t sig_body(input int row, input int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q = {q, 8'($urandom)};
    for (int i = 0; i < SigLength[row]; i++)
      if (SigOffset[row] + i < len) q[SigOffset[row] + i] = SigBytes[row][i];
    if (row == RowWebp)
      for (int i = 0; i < SigLength[RowRiff]; i++)
        if (i < len) q[i] = SigBytes[RowRiff][i];
    return q;
  endfunction

  function automatic byte_q_t flat_body(input logic [7:0] value, input int len);
    byte_q_t q;
    repeat (len) q = {q, value};
    return q;
  endfunction

  task automatic test_each_signature();
    for (int r = 0; r < RowRiff; r++) send_body(sig_body(r, SigMinBytes[r]));
    wait_drained();
  endtask

  task automatic test_edge_lengths();
    byte_q_t q;
    send_body(flat_body(8'hFF, 1));
    send_body(sig_body(RowZip, 3));
    send_body(sig_body(RowBmp, 13));
    send_body(sig_body(RowPng, 30));
    q = sig_body(RowWebp, 12);
    q[0] = 8'h00;
    send_body(q);
    q = sig_body(RowWebp, 14);
    q[3] = 8'h45;
    send_body(q);
    send_body(sig_body(RowWebp, 11));
    send_body(flat_body(8'h00, 8));
    send_body(flat_body(8'hFF, 4));
    wait_drained();
  endtask

  task automatic test_random_bodies();
    byte_q_t q;
    int      row;
    int      len;
    int      idx;
    while (bytes_sent < RandBytes) begin
      if ($urandom_range(0, 9) < 8) begin
        row = $urandom_range(0, RowRiff - 1);
        len = SigMinBytes[row] + $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, SigMinBytes[row]);
        q = sig_body(row, len);
        if ($urandom_range(0, 3) == 0) begin
          idx = $urandom_range(0, SigOffset[row] + SigLength[row] - 1);
          if (idx < q.size()) q[idx] = q[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
      end else begin
        q = {};
        repeat ($urandom_range(1, 20)) q = {q, 8'($urandom)};
      end
      send_body(q);
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    -> hold_ev;
    repeat (12) send_body(sig_body(RowGzip, $urandom_range(2, 5)));
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_drained_bodies();
    for (int i = 0; i < 6; i++) begin
      send_body(sig_body($urandom_range(0, RowRiff - 1), $urandom_range(1, 16)));
      wait_drained();
    end
  endtask

  initial begin : rx_hold
    hold_on = 1'b0;
    forever begin
      @(hold_ev);
      @(posedge clk_i);
      hold_on = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    int       period;
    int       tick;
    m_axis_tready_i = 1'b0;
    mode = RxAlways;
    mode_left = 0;
    period = 3;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
        period = $urandom_range(2, 7);
      end
      mode_left--;
      tick++;
      if (hold_on) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          RxAlways:   m_axis_tready_i <= 1'b1;
          RxRandom:   m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default:    m_axis_tready_i <= (tick % period != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [3:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_types.size() == 0) begin
        report_mismatch("unexpected type code", -1, int'(m_axis_tdata_o));
      end else begin
        want = expected_types.pop_front();
        if (m_axis_tdata_o[3:0] !== want)
          report_mismatch("type_code", int'(want), int'(m_axis_tdata_o[3:0]));
        if (m_axis_tdata_o[7:4] !== 4'd0)
          report_mismatch("tdata pad bits", 0, int'(m_axis_tdata_o[7:4]));
      end
    end
  end

  initial begin : main_seq
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    sig_pos         = 4'd0;
    sig_alive       = '1;
    err_count       = 0;
    bytes_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_each_signature();
    test_edge_lengths();
    test_random_bodies();
    test_output_backpressure();
    test_drained_bodies();
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> magic_signature_classifier.f
rtl/msc_pkg.sv
rtl/magic_signature_classifier.sv
verif/tb_top.sv
